// ===== sv/kbos_pkg.sv =====
// ----------------------------------------------------------------------------
// kbos_pkg: shared types and constants of the keypoint box overlap suppressor
// field widths, operation and outcome codes, controller states and the
// command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package kbos_pkg;

  localparam int CAPACITY      = 16;
  localparam int IDX_BITS      = 4;
  localparam int CNT_BITS      = 5;
  localparam int COORD_BITS    = 12;
  localparam int SIZE_BITS     = 10;
  localparam int BOX_BITS      = COORD_BITS + 2;
  localparam int ENTRY_BITS    = 2 * COORD_BITS + SIZE_BITS;
  localparam int FUNC_BITS     = 2;
  localparam int OUTCOME_BITS  = 3;
  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 80;

  typedef logic signed [BOX_BITS-1:0] box_t;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_INSERT = 2'd0,
    FN_CLEAR  = 2'd1,
    FN_READ   = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [OUTCOME_BITS-1:0] {
    OC_STORED    = 3'd0,
    OC_REPLACED  = 3'd1,
    OC_REJECTED  = 3'd2,
    OC_FULL      = 3'd3,
    OC_CLEARED   = 3'd4,
    OC_READ_OK   = 3'd5,
    OC_BAD_INDEX = 3'd6
  } outcome_t;

  typedef enum logic [1:0] {
    RA_IDX      = 2'd0,
    RA_IDX_NEXT = 2'd1,
    RA_READ     = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WS_APPEND = 2'd0,
    WS_LAST   = 2'd1,
    WS_SHIFT  = 2'd2
  } wr_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_DECODE    = 4'd1,
    ST_READ_WAIT = 4'd2,
    ST_CHECK     = 4'd3,
    ST_TEST      = 4'd4,
    ST_SHIFT_RD  = 4'd5,
    ST_SHIFT_WR  = 4'd6,
    ST_APPEND    = 4'd7,
    ST_FINISH    = 4'd8
  } state_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     ent_load;
    logic     match_load;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     idx_inc;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     res_load;
    outcome_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ri_ok;
    logic hit;
    logic bigger;
    logic idx_last;
    logic shift_last;
  } dp_status_t;

endpackage

// ===== sv/kbos_ram.sv =====
// ----------------------------------------------------------------------------
// kbos_ram: generic single write, single read RAM
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module kbos_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/kbos_dp.sv =====
// ----------------------------------------------------------------------------
// kbos_dp: datapath of the keypoint box overlap suppressor
// keypoint table, box corner tests, index and fill counters, result register
// ----------------------------------------------------------------------------
module kbos_dp import kbos_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [COORD_BITS-1:0]   in_x,
  input  logic [COORD_BITS-1:0]   in_y,
  input  logic [SIZE_BITS-1:0]    in_size,
  input  logic [IDX_BITS-1:0]     in_ri,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  output logic [OUTCOME_BITS-1:0] out_outcome,
  output logic [IDX_BITS-1:0]     out_match,
  output logic [COORD_BITS-1:0]   out_lx,
  output logic [COORD_BITS-1:0]   out_ly,
  output logic [SIZE_BITS-1:0]    out_ls,
  output logic [COORD_BITS-1:0]   out_ex,
  output logic [COORD_BITS-1:0]   out_ey,
  output logic [SIZE_BITS-1:0]    out_es,
  output logic [CNT_BITS-1:0]     out_count
);

  function automatic box_t box_lo(input logic [COORD_BITS-1:0] c,
                                  input logic [SIZE_BITS-1:0] s);
    box_lo = box_t'(BOX_BITS'(c) - BOX_BITS'(s >> 1));
  endfunction

  function automatic logic in_range(input box_t p, input box_t lo, input box_t hi);
    in_range = (p >= lo) && (p <= hi);
  endfunction

  function automatic logic corners_in(input box_t ax0, input box_t ax1,
                                      input box_t ay0, input box_t ay1,
                                      input box_t bx0, input box_t bx1,
                                      input box_t by0, input box_t by1);
    corners_in = (in_range(ax0, bx0, bx1) || in_range(ax1, bx0, bx1)) &&
                 (in_range(ay0, by0, by1) || in_range(ay1, by0, by1));
  endfunction

  // new keypoint and its box
  logic [COORD_BITS-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [SIZE_BITS-1:0]  ns_r, ns_nxt;
  logic [IDX_BITS-1:0]   ri_r, ri_nxt;
  box_t                  nbx0_r, nbx0_nxt, nbx1_r, nbx1_nxt;
  box_t                  nby0_r, nby0_nxt, nby1_r, nby1_nxt;

  // entry under test and its box
  logic [COORD_BITS-1:0] ent_x_r, ent_x_nxt, ent_y_r, ent_y_nxt;
  logic [SIZE_BITS-1:0]  ent_s_r, ent_s_nxt;
  box_t                  ebx0_r, ebx0_nxt, ebx1_r, ebx1_nxt;
  box_t                  eby0_r, eby0_nxt, eby1_r, eby1_nxt;

  logic [IDX_BITS-1:0]   idx_r, idx_nxt;
  logic [IDX_BITS-1:0]   match_r, match_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [CNT_BITS-1:0]   count_m1;

  // result register
  logic [OUTCOME_BITS-1:0] res_outcome_r, res_outcome_nxt;
  logic [IDX_BITS-1:0]     res_match_r, res_match_nxt;
  logic [COORD_BITS-1:0]   res_lx_r, res_lx_nxt, res_ly_r, res_ly_nxt;
  logic [SIZE_BITS-1:0]    res_ls_r, res_ls_nxt;
  logic [COORD_BITS-1:0]   res_ex_r, res_ex_nxt, res_ey_r, res_ey_nxt;
  logic [SIZE_BITS-1:0]    res_es_r, res_es_nxt;
  logic [CNT_BITS-1:0]     res_count_r, res_count_nxt;

  // table port
  logic                  ram_we;
  logic [IDX_BITS-1:0]   wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;
  logic [IDX_BITS-1:0]   rd_addr;
  logic [ENTRY_BITS-1:0] rd_data;
  logic [COORD_BITS-1:0] rd_x, rd_y;
  logic [SIZE_BITS-1:0]  rd_s;

  assign rd_x     = rd_data[COORD_BITS-1:0];
  assign rd_y     = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_s     = rd_data[ENTRY_BITS-1:2*COORD_BITS];
  assign count_m1 = count_r - CNT_BITS'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      RA_IDX:      rd_addr = idx_r;
      RA_IDX_NEXT: rd_addr = idx_r + IDX_BITS'(1);
      RA_READ:     rd_addr = ri_r;
      default:     rd_addr = idx_r;
    endcase
  end

  always_comb begin
    ram_we  = cmd.wr_en;
    wr_data = {ns_r, ny_r, nx_r};
    unique case (cmd.wr_sel)
      WS_APPEND: wr_addr = count_r[IDX_BITS-1:0];
      WS_LAST:   wr_addr = count_m1[IDX_BITS-1:0];
      WS_SHIFT: begin
        wr_addr = idx_r;
        wr_data = rd_data;
      end
      default:   wr_addr = count_r[IDX_BITS-1:0];
    endcase
  end

  kbos_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    nx_nxt   = nx_r;
    ny_nxt   = ny_r;
    ns_nxt   = ns_r;
    ri_nxt   = ri_r;
    nbx0_nxt = nbx0_r;
    nbx1_nxt = nbx1_r;
    nby0_nxt = nby0_r;
    nby1_nxt = nby1_r;
    if (cmd.load) begin
      nx_nxt   = in_x;
      ny_nxt   = in_y;
      ns_nxt   = in_size;
      ri_nxt   = in_ri;
      nbx0_nxt = box_lo(in_x, in_size);
      nbx1_nxt = box_lo(in_x, in_size) + box_t'(in_size);
      nby0_nxt = box_lo(in_y, in_size);
      nby1_nxt = box_lo(in_y, in_size) + box_t'(in_size);
    end
  end

  always_comb begin
    ent_x_nxt = ent_x_r;
    ent_y_nxt = ent_y_r;
    ent_s_nxt = ent_s_r;
    ebx0_nxt  = ebx0_r;
    ebx1_nxt  = ebx1_r;
    eby0_nxt  = eby0_r;
    eby1_nxt  = eby1_r;
    if (cmd.ent_load) begin
      ent_x_nxt = rd_x;
      ent_y_nxt = rd_y;
      ent_s_nxt = rd_s;
      ebx0_nxt  = box_lo(rd_x, rd_s);
      ebx1_nxt  = box_lo(rd_x, rd_s) + box_t'(rd_s);
      eby0_nxt  = box_lo(rd_y, rd_s);
      eby1_nxt  = box_lo(rd_y, rd_s) + box_t'(rd_s);
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    match_nxt = match_r;
    count_nxt = count_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_BITS'(1);
    end
    if (cmd.match_load) begin
      match_nxt = idx_r;
    end
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_BITS'(1);
    end
  end

  always_comb begin
    res_outcome_nxt = res_outcome_r;
    res_match_nxt   = res_match_r;
    res_lx_nxt      = res_lx_r;
    res_ly_nxt      = res_ly_r;
    res_ls_nxt      = res_ls_r;
    res_ex_nxt      = res_ex_r;
    res_ey_nxt      = res_ey_r;
    res_es_nxt      = res_es_r;
    res_count_nxt   = res_count_r;
    if (cmd.res_load) begin
      res_outcome_nxt = cmd.res_kind;
      res_match_nxt   = '0;
      res_lx_nxt      = '0;
      res_ly_nxt      = '0;
      res_ls_nxt      = '0;
      res_ex_nxt      = '0;
      res_ey_nxt      = '0;
      res_es_nxt      = '0;
      res_count_nxt   = count_r;
      if (cmd.res_kind == OC_REPLACED) begin
        res_match_nxt = match_r;
        res_lx_nxt    = ent_x_r;
        res_ly_nxt    = ent_y_r;
        res_ls_nxt    = ent_s_r;
      end else if (cmd.res_kind == OC_REJECTED) begin
        res_match_nxt = match_r;
        res_lx_nxt    = nx_r;
        res_ly_nxt    = ny_r;
        res_ls_nxt    = ns_r;
      end else if (cmd.res_kind == OC_READ_OK) begin
        res_ex_nxt = ent_x_r;
        res_ey_nxt = ent_y_r;
        res_es_nxt = ent_s_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nx_r          <= nx_nxt;
    ny_r          <= ny_nxt;
    ns_r          <= ns_nxt;
    ri_r          <= ri_nxt;
    nbx0_r        <= nbx0_nxt;
    nbx1_r        <= nbx1_nxt;
    nby0_r        <= nby0_nxt;
    nby1_r        <= nby1_nxt;
    ent_x_r       <= ent_x_nxt;
    ent_y_r       <= ent_y_nxt;
    ent_s_r       <= ent_s_nxt;
    ebx0_r        <= ebx0_nxt;
    ebx1_r        <= ebx1_nxt;
    eby0_r        <= eby0_nxt;
    eby1_r        <= eby1_nxt;
    match_r       <= match_nxt;
    res_outcome_r <= res_outcome_nxt;
    res_match_r   <= res_match_nxt;
    res_lx_r      <= res_lx_nxt;
    res_ly_r      <= res_ly_nxt;
    res_ls_r      <= res_ls_nxt;
    res_ex_r      <= res_ex_nxt;
    res_ey_r      <= res_ey_nxt;
    res_es_r      <= res_es_nxt;
    res_count_r   <= res_count_nxt;
  end

  always_comb begin
    status.full       = (count_r == CNT_BITS'(CAPACITY));
    status.empty      = (count_r == '0);
    status.ri_ok      = ({1'b0, ri_r} < count_r);
    status.hit        = corners_in(nbx0_r, nbx1_r, nby0_r, nby1_r,
                                   ebx0_r, ebx1_r, eby0_r, eby1_r) ||
                        corners_in(ebx0_r, ebx1_r, eby0_r, eby1_r,
                                   nbx0_r, nbx1_r, nby0_r, nby1_r);
    status.bigger     = (ns_r > ent_s_r);
    status.idx_last   = (CNT_BITS'(idx_r) + CNT_BITS'(1) == count_r);
    status.shift_last = (CNT_BITS'(idx_r) + CNT_BITS'(2) == count_r);
  end

  assign out_outcome = res_outcome_r;
  assign out_match   = res_match_r;
  assign out_lx      = res_lx_r;
  assign out_ly      = res_ly_r;
  assign out_ls      = res_ls_r;
  assign out_ex      = res_ex_r;
  assign out_ey      = res_ey_r;
  assign out_es      = res_es_r;
  assign out_count   = res_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(CAPACITY))
    else $error("table fill count beyond capacity");

  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ({1'b0, wr_addr} <= count_r))
    else $error("table write beyond the fill point");

  a_full_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !ram_we)
    else $error("table written while full");

endmodule

// ===== sv/kbos_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbos_ctrl: controller of the keypoint box overlap suppressor
// sequences decode, table walk, shift down, append and result hand-off
// ----------------------------------------------------------------------------
module kbos_ctrl import kbos_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [FUNC_BITS-1:0] in_func,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  dp_status_t           status,
  output dp_cmd_t              cmd
);

  state_t   state_r, state_nxt;
  func_t    func_r, func_nxt;
  outcome_t kind_r, kind_nxt;
  logic     out_tvalid_r, out_tvalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    kind_r <= kind_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    kind_nxt     = kind_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.rd_sel   = RA_IDX;
    cmd.wr_sel   = WS_APPEND;
    cmd.res_kind = kind_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          func_nxt  = func_t'(in_func);
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (func_r)
          FN_NOP: state_nxt = ST_IDLE;
          FN_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            kind_nxt    = OC_CLEARED;
            state_nxt   = ST_FINISH;
          end
          FN_READ: begin
            if (status.ri_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_READ;
              state_nxt  = ST_READ_WAIT;
            end else begin
              kind_nxt  = OC_BAD_INDEX;
              state_nxt = ST_FINISH;
            end
          end
          FN_INSERT: begin
            if (status.full) begin
              kind_nxt  = OC_FULL;
              state_nxt = ST_FINISH;
            end else if (status.empty) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_sel  = WS_APPEND;
              cmd.cnt_inc = 1'b1;
              kind_nxt    = OC_STORED;
              state_nxt   = ST_FINISH;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_IDX;
              state_nxt  = ST_CHECK;
            end
          end
        endcase
      end
      ST_READ_WAIT: begin
        cmd.ent_load = 1'b1;
        kind_nxt     = OC_READ_OK;
        state_nxt    = ST_FINISH;
      end
      ST_CHECK: begin
        cmd.ent_load = 1'b1;
        state_nxt    = ST_TEST;
      end
      ST_TEST: begin
        if (status.hit) begin
          cmd.match_load = 1'b1;
          if (status.bigger) begin
            kind_nxt = OC_REPLACED;
            if (status.idx_last) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WS_LAST;
              state_nxt  = ST_FINISH;
            end else begin
              state_nxt = ST_SHIFT_RD;
            end
          end else begin
            kind_nxt  = OC_REJECTED;
            state_nxt = ST_FINISH;
          end
        end else if (status.idx_last) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WS_APPEND;
          cmd.cnt_inc = 1'b1;
          kind_nxt    = OC_STORED;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RA_IDX_NEXT;
          state_nxt   = ST_CHECK;
        end
      end
      ST_SHIFT_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_IDX_NEXT;
        state_nxt  = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WS_SHIFT;
        if (status.shift_last) begin
          state_nxt = ST_APPEND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SHIFT_RD;
        end
      end
      ST_APPEND: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WS_LAST;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  assign out_tvalid = out_tvalid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_tvalid_r || out_tready))
    else $error("result register loaded over a pending beat");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DECODE))
    else $error("accepted beat not decoded");

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !out_tvalid_r) |=> out_tvalid_r)
    else $error("finished result not presented");

endmodule

// ===== sv/keypoint_box_overlap_suppressor_unit.sv =====
// ----------------------------------------------------------------------------
// keypoint_box_overlap_suppressor_unit: keypoint table with box overlap check
// keeps up to sixteen keypoints and drops the smaller of two overlapping boxes
// ----------------------------------------------------------------------------
// input beat: in_tuser selects insert, clear or read; in_tdata carries the
// keypoint centre and size, or the table position to read. every operation
// but the unused code returns exactly one result beat, whose kind is in
// out_tuser and whose loser, entry and fill count fields are in out_tdata.
// one operation is in flight at a time, walked through the table's write
// port and its registered read port. an insert walks the entries in order
// up to the first overlap; a replaced entry before the last has the later
// entries shifted down and the new keypoint appended last. each entry
// visited takes a table read, then a box corner test.
// reset empties the table; stored entries need no clearing.
// a result waits in the output register while out_tready is low; the next
// beat is taken meanwhile and its result waits until that register drains.
// ----------------------------------------------------------------------------
module keypoint_box_overlap_suppressor_unit import kbos_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // new_x, new_y, new_size, read_index, zero fill
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // func
  input  logic [FUNC_BITS-1:0]     in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // match_index, loser_x, loser_y, loser_size, entry_x, entry_y, entry_size,
  // count, zero fill
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // outcome
  output logic [OUTCOME_BITS-1:0]  out_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [IDX_BITS-1:0]   res_match;
  logic [COORD_BITS-1:0] res_lx, res_ly, res_ex, res_ey;
  logic [SIZE_BITS-1:0]  res_ls, res_es;
  logic [CNT_BITS-1:0]   res_count;

  kbos_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  kbos_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_x        (in_tdata[11:0]),
    .in_y        (in_tdata[23:12]),
    .in_size     (in_tdata[33:24]),
    .in_ri       (in_tdata[37:34]),
    .cmd         (cmd),
    .status      (status),
    .out_outcome (out_tuser),
    .out_match   (res_match),
    .out_lx      (res_lx),
    .out_ly      (res_ly),
    .out_ls      (res_ls),
    .out_ex      (res_ex),
    .out_ey      (res_ey),
    .out_es      (res_es),
    .out_count   (res_count)
  );

  assign out_tdata = {3'b000, res_count, res_es, res_ey, res_ex,
                      res_ls, res_ly, res_lx, res_match};

endmodule

// ===== dv/keypoint_box_overlap_suppressor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// keypoint_box_overlap_suppressor_unit_tb: self-checking bench for the unit
// drives insert, clear, read and unused beats under random source and sink
// gaps, tracks the keypoint table alongside the block and checks every
// result beat field by field against the predicted outcome
// ----------------------------------------------------------------------------
module keypoint_box_overlap_suppressor_unit_tb;
  import kbos_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    outcome_t               outcome;
    logic [IDX_BITS-1:0]    match;
    logic [COORD_BITS-1:0]  lx;
    logic [COORD_BITS-1:0]  ly;
    logic [SIZE_BITS-1:0]   ls;
    logic [COORD_BITS-1:0]  ex;
    logic [COORD_BITS-1:0]  ey;
    logic [SIZE_BITS-1:0]   es;
    logic [CNT_BITS-1:0]    cnt;
  } kp_result_t;

  typedef struct {
    int x0;
    int y0;
    int x1;
    int y1;
  } kp_box_t;

  class kp_table_tracker;
    logic [COORD_BITS-1:0] kp_x[CAPACITY];
    logic [COORD_BITS-1:0] kp_y[CAPACITY];
    logic [SIZE_BITS-1:0]  kp_s[CAPACITY];
    int                    n_kp;
    kp_result_t            due_results[$];
    int                    mismatch_cnt;

    function kp_box_t box_of(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                             logic [SIZE_BITS-1:0] s);
      kp_box_t b;
      b.x0 = int'(x) - int'(s) / 2;
      b.y0 = int'(y) - int'(s) / 2;
      b.x1 = b.x0 + int'(s);
      b.y1 = b.y0 + int'(s);
      return b;
    endfunction

    function bit pt_in(int px, int py, kp_box_t b);
      return px >= b.x0 && px <= b.x1 && py >= b.y0 && py <= b.y1;
    endfunction

    function bit corner_hit(kp_box_t a, kp_box_t b);
      return pt_in(a.x0, a.y0, b) || pt_in(a.x1, a.y0, b) ||
             pt_in(a.x0, a.y1, b) || pt_in(a.x1, a.y1, b);
    endfunction

    function void note_op(func_t f, logic [COORD_BITS-1:0] nx, logic [COORD_BITS-1:0] ny,
                          logic [SIZE_BITS-1:0] ns, logic [IDX_BITS-1:0] ri);
      kp_result_t r;
      kp_box_t    nb;
      kp_box_t    eb;
      int         hit_at;
      int         i;
      r = '0;
      case (f)
        FN_NOP: begin
          return;
        end
        FN_CLEAR: begin
          n_kp = 0;
          r.outcome = OC_CLEARED;
        end
        FN_READ: begin
          if (int'(ri) < n_kp) begin
            r.ex = kp_x[ri];
            r.ey = kp_y[ri];
            r.es = kp_s[ri];
            r.outcome = OC_READ_OK;
          end else begin
            r.outcome = OC_BAD_INDEX;
          end
        end
        default: begin
          if (n_kp >= CAPACITY) begin
            r.outcome = OC_FULL;
          end else begin
            nb = box_of(nx, ny, ns);
            hit_at = -1;
            for (i = 0; i < n_kp; i++) begin
              if (hit_at < 0) begin
                eb = box_of(kp_x[i], kp_y[i], kp_s[i]);
                if (corner_hit(nb, eb) || corner_hit(eb, nb)) hit_at = i;
              end
            end
            if (hit_at < 0) begin
              kp_x[n_kp] = nx;
              kp_y[n_kp] = ny;
              kp_s[n_kp] = ns;
              n_kp++;
              r.outcome = OC_STORED;
            end else if (ns > kp_s[hit_at]) begin
              r.match = hit_at[IDX_BITS-1:0];
              r.lx = kp_x[hit_at];
              r.ly = kp_y[hit_at];
              r.ls = kp_s[hit_at];
              for (i = hit_at; i < n_kp - 1; i++) begin
                kp_x[i] = kp_x[i+1];
                kp_y[i] = kp_y[i+1];
                kp_s[i] = kp_s[i+1];
              end
              kp_x[n_kp-1] = nx;
              kp_y[n_kp-1] = ny;
              kp_s[n_kp-1] = ns;
              r.outcome = OC_REPLACED;
            end else begin
              r.match = hit_at[IDX_BITS-1:0];
              r.lx = nx;
              r.ly = ny;
              r.ls = ns;
              r.outcome = OC_REJECTED;
            end
          end
        end
      endcase
      r.cnt = n_kp[CNT_BITS-1:0];
      due_results = {due_results, r};
    endfunction

    function void cmp_field(string fld, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("mismatch %s: expected %0d, got %0d", fld, want, got);
      end
    endfunction

    function void check_beat(logic [OUTCOME_BITS-1:0] oc, logic [OUT_DATA_BITS-1:0] d);
      kp_result_t e;
      if (due_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: outcome %0d, data %h", oc, d);
        return;
      end
      e = due_results.pop_front();
      cmp_field("outcome",     32'(e.outcome), 32'(oc));
      cmp_field("match_index", 32'(e.match),   32'(d[3:0]));
      cmp_field("loser_x",     32'(e.lx),      32'(d[15:4]));
      cmp_field("loser_y",     32'(e.ly),      32'(d[27:16]));
      cmp_field("loser_size",  32'(e.ls),      32'(d[37:28]));
      cmp_field("entry_x",     32'(e.ex),      32'(d[49:38]));
      cmp_field("entry_y",     32'(e.ey),      32'(d[61:50]));
      cmp_field("entry_size",  32'(e.es),      32'(d[71:62]));
      cmp_field("count",       32'(e.cnt),     32'(d[76:72]));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic [FUNC_BITS-1:0]     in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [OUTCOME_BITS-1:0]  out_tuser;

  kp_table_tracker kp_table = new();
  int              src_idle = 26;
  int              sink_idle = 81;
  int              ops_sent = 0;
  int              stall_cycles = 0;

  keypoint_box_overlap_suppressor_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) kp_table.check_beat(out_tuser, out_tdata);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("keypoint_box_overlap_suppressor_unit_tb NOT OK");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_beat(func_t f, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                           logic [SIZE_BITS-1:0] s, logic [IDX_BITS-1:0] ri);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {2'b00, ri, s, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    kp_table.note_op(f, x, y, s, ri);
    if (f != FN_NOP) ops_sent++;
  endtask

  task automatic insert_kp(int x, int y, int s);
    send_beat(FN_INSERT, x[COORD_BITS-1:0], y[COORD_BITS-1:0], s[SIZE_BITS-1:0],
              IDX_BITS'($urandom()));
  endtask

  task automatic read_kp(int ri);
    send_beat(FN_READ, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
              SIZE_BITS'($urandom()), ri[IDX_BITS-1:0]);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (kp_table.due_results.size() != 0);
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  task automatic directed_ops();
    read_kp(0);
    insert_kp(0, 0, 0);
    insert_kp(4095, 4095, 1023);
    insert_kp(2000, 100, 10);
    insert_kp(500, 500, 100);
    // edge touch with equal size is rejected
    insert_kp(2010, 100, 10);
    // larger box swallowing an entry replaces it
    insert_kp(2003, 100, 20);
    insert_kp(0, 0, 0);
    // replacing the head shifts the whole table down
    insert_kp(0, 0, 1);
    for (int i = 0; i < 5; i++) read_kp(i);
    send_beat(FN_NOP, 12'hfff, 12'hfff, 10'h3ff, 4'hf);
    read_kp(15);
    send_beat(FN_CLEAR, 12'hfff, 12'hfff, 10'h3ff, 4'hf);
    read_kp(0);
    insert_kp(4095, 0, 1023);
    insert_kp(0, 4095, 1022);
    read_kp(1);
  endtask

  task automatic run_episode();
    int mode;
    int n;
    int r;
    int j;
    int s;
    int sz;
    mode = $urandom_range(3);
    if ($urandom_range(3) != 0)
      send_beat(FN_CLEAR, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                SIZE_BITS'($urandom()), IDX_BITS'($urandom()));
    n = $urandom_range(22, 1);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        read_kp($urandom_range(15));
      end else if (r < 10) begin
        send_beat(FN_NOP, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                  SIZE_BITS'($urandom()), IDX_BITS'($urandom()));
      end else if (r < 11) begin
        send_beat(FN_CLEAR, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                  SIZE_BITS'($urandom()), IDX_BITS'($urandom()));
      end else begin
        case (mode)
          0: insert_kp($urandom_range(4095), $urandom_range(4095), $urandom_range(1023));
          // well-spaced grid fills the table
          1: insert_kp((k % 5) * 800 + 300, (k / 5) * 800 + 300, $urandom_range(300));
          2: insert_kp($urandom_range(1200, 1000), $urandom_range(1200, 1000),
                       $urandom_range(80));
          default: begin
            if (kp_table.n_kp == 0) begin
              insert_kp($urandom_range(4095), $urandom_range(4095), $urandom_range(1023));
            end else begin
              j = $urandom_range(kp_table.n_kp - 1);
              s = int'(kp_table.kp_s[j]) + 2;
              case ($urandom_range(2))
                0: sz = int'(kp_table.kp_s[j]);
                1: sz = (kp_table.kp_s[j] == '1) ? 1023 : int'(kp_table.kp_s[j]) + 1;
                default: sz = $urandom_range(1023);
              endcase
              insert_kp(clamp_coord(int'(kp_table.kp_x[j]) + int'($urandom_range(2 * s)) - s),
                        clamp_coord(int'(kp_table.kp_y[j]) + int'($urandom_range(2 * s)) - s),
                        sz);
            end
          end
        endcase
      end
    end
    // read the table back in order
    if ($urandom_range(1) == 1) begin
      for (int k = 0; k <= kp_table.n_kp && k < CAPACITY; k++) read_kp(k);
    end
  endtask

  task automatic random_phase(int target);
    int start;
    start = ops_sent;
    while (ops_sent - start < target) run_episode();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_ops();
    random_phase(320);
    drain_results();
    src_idle = 81;
    sink_idle = 26;
    random_phase(330);
    drain_results();
    src_idle = 0;
    sink_idle = 0;
    random_phase(330);
    drain_results();
    repeat (60) @(posedge clk);
    if (kp_table.mismatch_cnt == 0 && kp_table.due_results.size() == 0) begin
      $display("keypoint_box_overlap_suppressor_unit_tb OK");
    end else begin
      $display("keypoint_box_overlap_suppressor_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== keypoint_box_overlap_suppressor_unit.f =====
sv/kbos_pkg.sv
sv/kbos_ram.sv
sv/kbos_dp.sv
sv/kbos_ctrl.sv
sv/keypoint_box_overlap_suppressor_unit.sv
dv/keypoint_box_overlap_suppressor_unit_tb.sv
